### hw/rtl/periodic_timer_dispatcher_core_assert.svh
// ----------------------------------------------------------------------------
// Periodic timer dispatcher assertion macros
// Shorthand for the concurrent checks used by the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_DISPATCHER_CORE_ASSERT_SVH
`define PERIODIC_TIMER_DISPATCHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer dispatcher package
// Shared widths, opcodes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    // Default table size and time width.
    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // Field widths of the stream items.
    localparam int OPCODE_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int NOW_W       = 32;
    localparam int PERIOD_W    = 32;
    localparam int MODE_W      = 2;
    localparam int FIRE_TIME_W = 32;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_FIELDS_W  = OPCODE_W + SLOT_W + NOW_W + PERIOD_W + MODE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + FIRE_TIME_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DONE     = 2'd2;

    // Bit positions inside the overrun mode.
    localparam int MODE_SKIP_BIT  = 0;
    localparam int MODE_DELAY_BIT = 1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FLUSH
    } ptd_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic reg_write;
        logic busy_clear;
        logic tick_start;
        logic issue;
        logic flush_push;
    } ptd_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic stall;
        logic eval_vld;
        logic hold_vld;
        logic out_free;
        logic scan_last;
    } ptd_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ptd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic timer dispatcher controller
// Sequences item intake, the slot scan of a tick and the final result flush.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_timer_dispatcher_core_assert.svh"

module ptd_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic [ptd_pkg::OPCODE_W-1:0]    in_opcode,
    output logic                                 in_ready,
    input  wire ptd_pkg::ptd_stat_t              stat,
    output ptd_pkg::ptd_cmd_t                    cmd
);

    import ptd_pkg::*;

    ptd_state_t state_reg;
    ptd_state_t state_next;
    logic       accept;

    assign accept = in_valid && (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_opcode == OP_TICK))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat.stall && stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.stall)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!stat.hold_vld || stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    case (in_opcode)
                        OP_REGISTER: cmd.reg_write  = 1'b1;
                        OP_TICK:     cmd.tick_start = 1'b1;
                        OP_DONE:     cmd.busy_clear = 1'b1;
                        default:     cmd            = '0;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.issue = !stat.stall;
            end
            S_DRAIN:
            begin
                cmd = '0;
            end
            S_FLUSH:
            begin
                cmd.flush_push = stat.hold_vld && stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A pending dispatch must never be left behind when the block goes idle.
    `PTD_ASSERT_IMP(a_idle_no_hold, clk, rst_n, state_reg == S_IDLE, !stat.hold_vld,
        "pending dispatch while idle")
    // The evaluation stage is only busy during a scan or the drain that follows it.
    `PTD_ASSERT_IMP(a_eval_in_scan, clk, rst_n, stat.eval_vld,
        (state_reg == S_SCAN) || (state_reg == S_DRAIN), "evaluation outside scan")
    // Every unstalled scan cycle feeds the evaluation stage.
    `PTD_ASSERT_NXT(a_scan_feeds_eval, clk, rst_n, (state_reg == S_SCAN) && !stat.stall,
        stat.eval_vld, "scan read did not reach evaluation")

endmodule

`default_nettype wire

### hw/rtl/ptd_dp.sv
// ----------------------------------------------------------------------------
// Periodic timer dispatcher datapath
// Slot table, scan pipeline, expiry evaluation and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_timer_dispatcher_core_assert.svh"

module ptd_dp #(
    parameter int NUM_TIMERS = ptd_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = ptd_pkg::TIME_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ptd_pkg::ptd_cmd_t                  cmd,
    output ptd_pkg::ptd_stat_t                      stat,
    input  wire logic [ptd_pkg::SLOT_W-1:0]         in_slot,
    input  wire logic [ptd_pkg::NOW_W-1:0]          in_now_time,
    input  wire logic [ptd_pkg::PERIOD_W-1:0]       in_interval,
    input  wire logic [ptd_pkg::MODE_W-1:0]         in_overrun_mode,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic      [ptd_pkg::SLOT_W-1:0]         out_slot,
    output logic      [ptd_pkg::FIRE_TIME_W-1:0]    out_time,
    output logic                                    out_last
);

    import ptd_pkg::*;

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int WORD_W = MODE_W + PERIOD_W + TIME_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // Per-slot flags, cleared by reset.
    logic [NUM_TIMERS-1:0]  valid_reg, valid_next;
    logic [NUM_TIMERS-1:0]  busy_reg, busy_next;

    // Scan pipeline.
    logic [TIME_BITS-1:0]   tick_now_reg, tick_now_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       eval_idx_reg, eval_idx_next;
    logic                   eval_vld_reg, eval_vld_next;

    // One dispatch held back until it is known whether it is the last one.
    logic                   hold_vld_reg, hold_vld_next;
    logic [SLOT_W-1:0]      hold_slot_reg, hold_slot_next;

    // Result register.
    logic                   out_vld_reg, out_vld_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [FIRE_TIME_W-1:0] out_time_reg, out_time_next;
    logic                   out_last_reg, out_last_next;

    // Table memory and its decoded read word.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;
    logic [TIME_BITS-1:0]   rd_expiry;
    logic [PERIOD_W-1:0]    rd_period;
    logic [MODE_W-1:0]      rd_mode;

    // Evaluation and item decode.
    logic                   slot_busy;
    logic                   due;
    logic                   fire_want;
    logic                   skip_rearm;
    logic                   out_free;
    logic                   stall;
    logic                   fire_go;
    logic                   rearm;
    logic [TIME_BITS-1:0]   rearm_expiry;
    logic                   slot_hit;
    logic [IDX_W-1:0]       item_idx;
    logic [TIME_BITS-1:0]   reg_expiry;

    ptd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_TIMERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_expiry = ram_rdata[TIME_BITS-1:0];
    assign rd_period = ram_rdata[TIME_BITS +: PERIOD_W];
    assign rd_mode   = ram_rdata[TIME_BITS + PERIOD_W +: MODE_W];

    // Decode of register and done items.
    assign slot_hit   = (32'(in_slot) < NUM_TIMERS);
    assign item_idx   = IDX_W'(in_slot);
    assign reg_expiry = TIME_BITS'(in_now_time) + TIME_BITS'(in_interval);

    // Expiry check and overrun handling for the slot in evaluation.
    assign slot_busy    = busy_reg[eval_idx_reg];
    assign due          = eval_vld_reg && valid_reg[eval_idx_reg]
                          && (tick_now_reg >= rd_expiry);
    assign fire_want    = due && (!slot_busy
                          || (!rd_mode[MODE_SKIP_BIT] && !rd_mode[MODE_DELAY_BIT]));
    assign skip_rearm   = due && slot_busy && rd_mode[MODE_SKIP_BIT];
    assign out_free     = !out_vld_reg || out_ready;
    assign stall        = fire_want && hold_vld_reg && !out_free;
    assign fire_go      = fire_want && !stall;
    assign rearm        = fire_go || skip_rearm;
    assign rearm_expiry = tick_now_reg + TIME_BITS'(rd_period);

    // Table port selection; a stalled evaluation rereads its own slot.
    always_comb
    begin
        ram_raddr = stall ? eval_idx_reg : idx_reg;
        ram_we    = rearm || (cmd.reg_write && slot_hit);
        if (rearm)
        begin
            ram_waddr = eval_idx_reg;
            ram_wdata = {rd_mode, rd_period, rearm_expiry};
        end
        else
        begin
            ram_waddr = item_idx;
            ram_wdata = {in_overrun_mode, in_interval, reg_expiry};
        end
    end

    // Next values of flags, scan pipeline and result registers.
    always_comb
    begin
        valid_next     = valid_reg;
        busy_next      = busy_reg;
        tick_now_next  = tick_now_reg;
        idx_next       = idx_reg;
        eval_idx_next  = eval_idx_reg;
        eval_vld_next  = stall ? eval_vld_reg : cmd.issue;
        hold_vld_next  = hold_vld_reg;
        hold_slot_next = hold_slot_reg;
        out_vld_next   = out_vld_reg;
        out_slot_next  = out_slot_reg;
        out_time_next  = out_time_reg;
        out_last_next  = out_last_reg;

        if (cmd.reg_write && slot_hit)
        begin
            valid_next[item_idx] = 1'b1;
            busy_next[item_idx]  = 1'b0;
        end
        if (cmd.busy_clear && slot_hit)
        begin
            busy_next[item_idx] = 1'b0;
        end
        if (cmd.tick_start)
        begin
            tick_now_next = TIME_BITS'(in_now_time);
            idx_next      = '0;
        end
        if (cmd.issue)
        begin
            idx_next      = idx_reg + 1'b1;
            eval_idx_next = idx_reg;
        end

        // Retire an accepted result.
        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end

        // A new dispatch pushes the held one out as a non-final result.
        if (fire_go)
        begin
            busy_next[eval_idx_reg] = 1'b1;
            hold_vld_next           = 1'b1;
            hold_slot_next          = SLOT_W'(eval_idx_reg);
            if (hold_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_slot_next = hold_slot_reg;
                out_time_next = FIRE_TIME_W'(tick_now_reg);
                out_last_next = 1'b0;
            end
        end

        // End of scan: the held dispatch is the last one of this tick.
        if (cmd.flush_push)
        begin
            hold_vld_next = 1'b0;
            out_vld_next  = 1'b1;
            out_slot_next = hold_slot_reg;
            out_time_next = FIRE_TIME_W'(tick_now_reg);
            out_last_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            busy_reg     <= '0;
            idx_reg      <= '0;
            eval_vld_reg <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            eval_vld_reg <= eval_vld_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tick_now_reg  <= tick_now_next;
        eval_idx_reg  <= eval_idx_next;
        hold_slot_reg <= hold_slot_next;
        out_slot_reg  <= out_slot_next;
        out_time_reg  <= out_time_next;
        out_last_reg  <= out_last_next;
    end

    // Status and outputs.
    assign stat.stall     = stall;
    assign stat.eval_vld  = eval_vld_reg;
    assign stat.hold_vld  = hold_vld_reg;
    assign stat.out_free  = out_free;
    assign stat.scan_last = (idx_reg == LAST_IDX);

    assign out_valid = out_vld_reg;
    assign out_slot  = out_slot_reg;
    assign out_time  = out_time_reg;
    assign out_last  = out_last_reg;

    // Register writes and scan write-backs never share the table write port.
    `PTD_ASSERT_IMP(a_reg_not_in_scan, clk, rst_n, cmd.reg_write, !eval_vld_reg,
        "register item during scan")
    // A held dispatch is only displaced when the result register can take it.
    `PTD_ASSERT_IMP(a_hold_not_lost, clk, rst_n, fire_go && hold_vld_reg, out_free,
        "held dispatch overwritten")
    // The final flush empties the hold stage.
    `PTD_ASSERT_NXT(a_flush_empties, clk, rst_n, cmd.flush_push, !hold_vld_reg,
        "hold stage not empty after flush")

endmodule

`default_nettype wire

### hw/rtl/periodic_timer_dispatcher_core.sv
// ----------------------------------------------------------------------------
// Periodic timer dispatcher core
// Table of periodic timers scanned on each time tick, one dispatch per due
// slot that is not held back as busy by a skip or delay overrun mode.
// ----------------------------------------------------------------------------
// Register and job-done items are handled while idle and leave the block
// ready for more items. A tick scans the slot table one slot per cycle
// through the single read port of the table memory while no held-back
// dispatch stalls it, then drains the evaluation stage and flushes the
// last dispatch before it returns to idle. Results of a tick leave in slot
// order and the last one of the tick carries tlast. No input is taken during a scan.
`default_nettype none

module periodic_timer_dispatcher_core #(
    parameter int NUM_TIMERS = ptd_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = ptd_pkg::TIME_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Fields from bit 0: opcode, slot, now_time, interval, overrun_mode.
    input  wire logic [ptd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: fired_slot, fire_time, zero padding.
    output logic      [ptd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                   m_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready
);

    import ptd_pkg::*;

    localparam int SLOT_LSB   = OPCODE_W;
    localparam int NOW_LSB    = SLOT_LSB + SLOT_W;
    localparam int PERIOD_LSB = NOW_LSB + NOW_W;
    localparam int MODE_LSB   = PERIOD_LSB + PERIOD_W;

    logic [OPCODE_W-1:0]    in_opcode;
    logic [SLOT_W-1:0]      in_slot;
    logic [NOW_W-1:0]       in_now_time;
    logic [PERIOD_W-1:0]    in_interval;
    logic [MODE_W-1:0]      in_overrun_mode;
    logic [SLOT_W-1:0]      out_slot;
    logic [FIRE_TIME_W-1:0] out_time;
    ptd_cmd_t               cmd;
    ptd_stat_t              stat;

    // Input field unpacking.
    assign in_opcode       = s_axis_tdata[0 +: OPCODE_W];
    assign in_slot         = s_axis_tdata[SLOT_LSB +: SLOT_W];
    assign in_now_time     = s_axis_tdata[NOW_LSB +: NOW_W];
    assign in_interval     = s_axis_tdata[PERIOD_LSB +: PERIOD_W];
    assign in_overrun_mode = s_axis_tdata[MODE_LSB +: MODE_W];

    ptd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (in_opcode),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptd_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_slot         (in_slot),
        .in_now_time     (in_now_time),
        .in_interval     (in_interval),
        .in_overrun_mode (in_overrun_mode),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_slot        (out_slot),
        .out_time        (out_time),
        .out_last        (m_axis_tlast)
    );

    // Result packing with zero fill up to the byte boundary.
    assign m_axis_tdata = OUT_TDATA_W'({out_time, out_slot});

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Periodic timer dispatcher core testbench
// Drives register, tick and done transfers into the timer table and checks
// every dispatch against an in-bench model of the slot table.
// ----------------------------------------------------------------------------
// A short directed sequence covers each overrun mode, the field extremes,
// expiry wraparound, re-registration, done on an idle slot and the unused
// opcode. A random sequence follows. Most of it is a time base that moves
// forward in small steps, with short periods so that slots fall due often.
// The rest is random jumps in time and full-range fields. Both stream sides
// idle at random. Once, the result side holds off for a long stretch while
// ticks keep coming, so that the core backs up and stalls its input.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ptd_pkg::*;

    localparam int NUM_SLOTS = NUM_TIMERS_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS = 250;

    // Overrun modes, plus the opcode that the core ignores.
    localparam logic [MODE_W-1:0] MODE_OVERLAP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SKIP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELAY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd3;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // One input transfer, packed in the same order as s_axis_tdata.
    typedef struct packed {
        logic [MODE_W-1:0] overrun_mode;
        logic [PERIOD_W-1:0] interval;
        logic [NOW_W-1:0] now_time;
        logic [SLOT_W-1:0] slot;
        logic [OPCODE_W-1:0] opcode;
    } timer_item_t;

    // One dispatch leaving the core.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [FIRE_TIME_W-1:0] fire_time;
        logic last;
    } dispatch_t;

    // Model of the slot table and the queue of dispatches it predicts.
    class timer_table_model;
        bit slot_on[NUM_SLOTS];
        bit slot_busy[NUM_SLOTS];
        logic [PERIOD_W-1:0] slot_period[NUM_SLOTS];
        logic [NOW_W-1:0] slot_due_at[NUM_SLOTS];
        logic [MODE_W-1:0] slot_mode[NUM_SLOTS];
        dispatch_t pending_dispatches[$];
        int mismatches;

        function int pending();
            return pending_dispatches.size();
        endfunction

        // Updates the table for an accepted input and queues its dispatches.
        function void apply_item(timer_item_t it);
            dispatch_t fired[$];
            dispatch_t d;
            int i;
            if (it.opcode == OP_REGISTER)
            begin
                slot_on[it.slot] = 1'b1;
                slot_period[it.slot] = it.interval;
                slot_mode[it.slot] = it.overrun_mode;
                slot_due_at[it.slot] = it.now_time + it.interval;
                slot_busy[it.slot] = 1'b0;
            end
            else if (it.opcode == OP_DONE)
            begin
                slot_busy[it.slot] = 1'b0;
            end
            else if (it.opcode == OP_TICK)
            begin
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!slot_on[i] || it.now_time < slot_due_at[i])
                        continue;
                    if (slot_busy[i])
                    begin
                        // The skip test wins over the delay test.
                        if (slot_mode[i][MODE_SKIP_BIT])
                        begin
                            slot_due_at[i] = it.now_time + slot_period[i];
                            continue;
                        end
                        if (slot_mode[i][MODE_DELAY_BIT])
                            continue;
                    end
                    slot_due_at[i] = it.now_time + slot_period[i];
                    slot_busy[i] = 1'b1;
                    d.slot = i[SLOT_W-1:0];
                    d.fire_time = it.now_time;
                    d.last = 1'b0;
                    fired.push_back(d);
                end
                if (fired.size() > 0)
                    fired[fired.size()-1].last = 1'b1;
                foreach (fired[k])
                    pending_dispatches.push_back(fired[k]);
            end
        endfunction

        // Compares one dispatch from the core with the oldest prediction.
        function void check_dispatch(logic [SLOT_W-1:0] slot,
                                     logic [FIRE_TIME_W-1:0] fire_time, logic last);
            dispatch_t want;
            if (pending_dispatches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected dispatch: slot %0d time %h last %0b",
                             slot, fire_time, last);
                return;
            end
            want = pending_dispatches.pop_front();
            if (want.slot !== slot || want.fire_time !== fire_time || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("dispatch differs: expected slot %0d time %h last %0b, got slot %0d time %h last %0b",
                             want.slot, want.fire_time, want.last, slot, fire_time, last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;

    timer_table_model table_model = new();
    int accepted_items = 0;
    int cycle_count = 0;
    int rx_stall = 0;
    bit hold_off = 1'b0;
    bit steady = 1'b0;

    periodic_timer_dispatcher_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function timer_item_t make_item(logic [OPCODE_W-1:0] opcode, logic [SLOT_W-1:0] slot,
                                    logic [NOW_W-1:0] now_time,
                                    logic [PERIOD_W-1:0] interval,
                                    logic [MODE_W-1:0] overrun_mode);
        timer_item_t it;
        it.opcode = opcode;
        it.slot = slot;
        it.now_time = now_time;
        it.interval = interval;
        it.overrun_mode = overrun_mode;
        return it;
    endfunction

    // Offers one item, after an optional idle gap, and waits for the transfer.
    task automatic send_item(timer_item_t it);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= it;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        table_model.apply_item(it);
        accepted_items++;
    endtask

    // Result side: check each transfer, then decide whether to stall.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            table_model.check_dispatch(m_axis_tdata[SLOT_W-1:0],
                                       m_axis_tdata[SLOT_W +: FIRE_TIME_W], m_axis_tlast);
        if (!rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end
        else if (!steady && $urandom_range(0, 3) == 0)
        begin
            rx_stall = pick_gap();
            m_axis_tready <= (rx_stall == 0);
            if (rx_stall > 0)
                rx_stall = rx_stall - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Long hold-off on the result side while input keeps arriving.
    initial
    begin
        wait (accepted_items >= 60);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("periodic_timer_dispatcher_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        timer_item_t it;
        logic [NOW_W-1:0] clock_now;
        int counted;
        int step;
        int r;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a tick on an empty table, then one slot per overrun mode.
        send_item(make_item(OP_TICK, 4'd0, 32'd0, 32'd0, MODE_OVERLAP));
        send_item(make_item(OP_REGISTER, 4'd0, 32'd0, 32'd0, MODE_OVERLAP));
        send_item(make_item(OP_REGISTER, 4'd15, 32'd0, 32'd5, MODE_SKIP));
        send_item(make_item(OP_REGISTER, 4'd7, 32'd0, 32'd5, MODE_DELAY));
        send_item(make_item(OP_REGISTER, 4'd3, 32'd0, 32'd5, MODE_BOTH));
        send_item(make_item(OP_REGISTER, 4'd9, 32'd0, 32'hFFFF_FFFF, MODE_OVERLAP));
        // Zero period is due at once; later ticks catch slots while busy.
        send_item(make_item(OP_TICK, 4'd0, 32'd0, 32'd0, MODE_OVERLAP));
        send_item(make_item(OP_TICK, 4'd0, 32'd5, 32'd0, MODE_OVERLAP));
        send_item(make_item(OP_TICK, 4'd0, 32'd10, 32'd0, MODE_OVERLAP));
        send_item(make_item(OP_DONE, 4'd7, 32'd0, 32'd0, MODE_OVERLAP));
        send_item(make_item(OP_TICK, 4'd0, 32'd11, 32'd0, MODE_OVERLAP));
        // Done on a slot that was never registered, and the unused opcode.
        send_item(make_item(OP_DONE, 4'd4, 32'd0, 32'd0, MODE_OVERLAP));
        send_item(make_item(OP_UNUSED, 4'd9, 32'h1234_5678, 32'h8765_4321, MODE_BOTH));
        // Re-register a busy slot, then a tick at the top of the time range.
        send_item(make_item(OP_REGISTER, 4'd0, 32'd20, 32'd3, MODE_DELAY));
        send_item(make_item(OP_TICK, 4'd0, 32'hFFFF_FFFF, 32'd0, MODE_OVERLAP));
        // Expiry that wraps past zero.
        send_item(make_item(OP_REGISTER, 4'd5, 32'hFFFF_FFF0, 32'h20, MODE_OVERLAP));
        send_item(make_item(OP_TICK, 4'd0, 32'h10, 32'd0, MODE_OVERLAP));
        send_item(make_item(OP_DONE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_BOTH));
        send_item(make_item(OP_TICK, 4'd0, 32'h20, 32'd0, MODE_OVERLAP));

        // Random: a time base moving forward, with some jumps and noise.
        clock_now = 32'h20;
        counted = 0;
        step = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (step % 40 == 0)
                steady <= ($urandom_range(0, 3) == 0);
            step++;
            it = IN_TDATA_W'({$urandom(), $urandom(), $urandom()});
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                // Ignored opcode; does not count.
                it.opcode = OP_UNUSED;
                send_item(it);
                continue;
            end
            if (r < 9)
            begin
                // Full-range register or tick with no regard for the time base.
                it.opcode = ($urandom_range(0, 1) == 0) ? OP_REGISTER : OP_TICK;
            end
            else if (r < 26)
            begin
                it.opcode = OP_REGISTER;
                it.now_time = clock_now;
                r = $urandom_range(0, 9);
                if (r < 7)
                    it.interval = $urandom_range(1, 20);
                else if (r < 8)
                    it.interval = '0;
                else
                    it.interval = $urandom();
            end
            else if (r < 70)
            begin
                it.opcode = OP_TICK;
                if ($urandom_range(0, 19) == 0)
                    clock_now = $urandom();
                else
                    clock_now = clock_now + $urandom_range(0, 8);
                it.now_time = clock_now;
            end
            else
                it.opcode = OP_DONE;
            send_item(it);
            counted++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow a full scan for anything left over.
        while (table_model.pending() != 0)
            @(posedge clk);
        repeat (3 * NUM_SLOTS + 10) @(posedge clk);
        if (table_model.mismatches == 0 && table_model.pending() == 0)
            $display("periodic_timer_dispatcher_core: match");
        else
            $display("periodic_timer_dispatcher_core: mismatch");
        $finish;
    end

endmodule
